// File: design/ugbb_pkg.sv
// Shared types, constants and helpers for the uniform grid box binning block.
// No dependencies; the front, queue and back files and the top level import it.
package ugbb_pkg;

  localparam int MaxDim   = 4;   // largest grid edge the word formats carry
  localparam int BndW     = 36;  // signed width of exact voxel bounds
  localparam int CoordW   = 32;
  localparam int CellW    = 31;
  localparam int TagW     = 16;
  localparam int CountW   = 16;
  localparam int VoxIdxW  = 6;
  localparam int CfgIdxW  = 3;
  localparam int QDepth   = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] CfgOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginZ = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCellX   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCellY   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCellZ   = 3'd5;

  // classified box: per-axis cell hit masks plus the tag
  typedef struct packed {
    logic [2:0][MaxDim-1:0] hit;
    logic [TagW-1:0]        tag;
  } qent_t;

  typedef struct packed {
    logic [VoxIdxW-1:0] voxel_index;
    logic [TagW-1:0]    tag_out;
    logic [CountW-1:0]  slot;
    logic               count_full;
    logic               no_voxel;
    logic               last;
  } res_t;

  // strict interval overlap on one axis
  function automatic logic axis_hit(input logic signed [BndW-1:0] lo,
                                    input logic signed [BndW-1:0] hi,
                                    input logic signed [BndW-1:0] bmin,
                                    input logic signed [BndW-1:0] bmax);
    logic h;
    if (lo < bmin) h = (bmin < hi);
    else           h = (lo < bmax);
    return h;
  endfunction

endpackage

// File: design/ugbb_if.sv
// Channel interfaces: box words in, bin result words out.
// Depends on nothing; payload widths match ugbb_pkg.
interface ugbb_box_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic [15:0]        object_tag;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, object_tag, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, object_tag, output ready);
endinterface

interface ugbb_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  voxel_index;
  logic [15:0] tag_out;
  logic [15:0] slot;
  logic        count_full;
  logic        no_voxel;
  logic        last;

  modport source (output valid, voxel_index, tag_out, slot, count_full,
                  no_voxel, last, input ready);
  modport sink   (input valid, voxel_index, tag_out, slot, count_full,
                  no_voxel, last, output ready);
endinterface

// File: design/ugbb_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ugbb_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];  // old data on same-address write
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/ugbb_front.sv
// Front end: configuration registers, voxel bound table, input stage and
// per-axis overlap classification. Depends on ugbb_pkg and ugbb_box_if.
module ugbb_front import ugbb_pkg::*; #(
  parameter int GRID_DIM = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  ugbb_box_if.sink           box_i,
  output logic               push_o,
  output qent_t              push_data_o,
  input  logic               full_i
);
  logic [CoordW-1:0] origin_q [3];
  logic [CellW-1:0]  cell_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        origin_q[a] <= '0;
        cell_q[a]   <= CellW'(65536);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOriginX: origin_q[0] <= cfg_wdata_i;
        CfgOriginY: origin_q[1] <= cfg_wdata_i;
        CfgOriginZ: origin_q[2] <= cfg_wdata_i;
        CfgCellX:   cell_q[0]   <= cfg_wdata_i[CellW-1:0];
        CfgCellY:   cell_q[1]   <= cfg_wdata_i[CellW-1:0];
        CfgCellZ:   cell_q[2]   <= cfg_wdata_i[CellW-1:0];
        default: ;
      endcase
    end
  end

  // bound table, refreshed every cycle from the config registers
  logic signed [BndW-1:0] lo_q [3][GRID_DIM];
  logic signed [BndW-1:0] hi_q [3][GRID_DIM];

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < GRID_DIM; k++) begin
        lo_q[a][k] <= $signed({{(BndW-CoordW){origin_q[a][CoordW-1]}}, origin_q[a]})
                    + $signed({{(BndW-CellW){1'b0}}, cell_q[a]} * BndW'(k));
        hi_q[a][k] <= $signed({{(BndW-CoordW){origin_q[a][CoordW-1]}}, origin_q[a]})
                    + $signed({{(BndW-CellW){1'b0}}, cell_q[a]} * BndW'(k + 1));
      end
    end
  end

  // input stage
  logic                   st_vld_q;
  logic [CoordW-1:0]      st_min_q [3];
  logic [CoordW-1:0]      st_max_q [3];
  logic [TagW-1:0]        st_tag_q;
  logic                   accept;

  assign push_o      = st_vld_q && !full_i;
  assign box_i.ready = !st_vld_q || !full_i;
  assign accept      = box_i.valid && box_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else if (box_i.ready) begin
      st_vld_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_min_q[0] <= box_i.box_min_x;
      st_min_q[1] <= box_i.box_min_y;
      st_min_q[2] <= box_i.box_min_z;
      st_max_q[0] <= box_i.box_max_x;
      st_max_q[1] <= box_i.box_max_y;
      st_max_q[2] <= box_i.box_max_z;
      st_tag_q    <= box_i.object_tag;
    end
  end

  // classification: one compare pair per cell and axis
  always_comb begin
    logic signed [BndW-1:0] bmin;
    logic signed [BndW-1:0] bmax;
    push_data_o     = '0;
    push_data_o.tag = st_tag_q;
    for (int a = 0; a < 3; a++) begin
      bmin = $signed({{(BndW-CoordW){st_min_q[a][CoordW-1]}}, st_min_q[a]});
      bmax = $signed({{(BndW-CoordW){st_max_q[a][CoordW-1]}}, st_max_q[a]});
      for (int k = 0; k < GRID_DIM; k++) begin
        push_data_o.hit[a][k] = axis_hit(lo_q[a][k], hi_q[a][k], bmin, bmax);
      end
    end
  end
endmodule

// File: design/ugbb_queue.sv
// Two-entry queue of classified boxes between front and back.
// Depends on ugbb_pkg.
module ugbb_queue import ugbb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  output logic  vld_o,
  output qent_t head_o,
  input  logic  pop_i
);
  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  qent_t           ent_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(QDepth));
  assign vld_o  = (cnt_q != '0);
  assign head_o = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= push_data_i;
  end
endmodule

// File: design/ugbb_back.sv
// Back end: voxel scan over the queue head, count store update and the
// result register. Depends on ugbb_pkg, ugbb_ram and ugbb_res_if.
module ugbb_back import ugbb_pkg::*; #(
  parameter int GRID_DIM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_vld_i,
  input  qent_t       q_head_i,
  output logic        q_pop_o,
  ugbb_res_if.source  res_o
);
  localparam int NumVox = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AddrW  = (NumVox > 1) ? $clog2(NumVox) : 1;

  // voxel hit mask from the three axis masks
  logic [NumVox-1:0] hit, above;
  logic [VoxIdxW-1:0] sc_q;

  for (genvar i = 0; i < NumVox; i++) begin : g_vox
    assign hit[i] = q_head_i.hit[0][i % GRID_DIM]
                  & q_head_i.hit[1][(i / GRID_DIM) % GRID_DIM]
                  & q_head_i.hit[2][i / (GRID_DIM * GRID_DIM)];
    assign above[i] = (VoxIdxW'(i) > sc_q);
  end

  logic any_hit, cur_hit, cur_last;
  assign any_hit  = |hit;
  assign cur_hit  = hit[sc_q[AddrW-1:0]];
  assign cur_last = ~|(hit & above);

  // stage 1: count read in flight
  logic               p1_vld_q, p1_nov_q, p1_last_q, p1_cv_q, p1_fwd_q;
  logic [VoxIdxW-1:0] p1_idx_q;
  logic [TagW-1:0]    p1_tag_q;
  logic [CountW-1:0]  fwd_q;
  logic               ov_q;
  res_t               res_q;

  logic              out_free, adv, issue;
  logic [CountW-1:0] rdata, cnt;
  logic              full, we;
  logic [CountW-1:0] wdata;
  logic [NumVox-1:0] vbit_q;

  assign out_free = !ov_q || res_o.ready;
  assign adv      = !p1_vld_q || out_free;
  assign issue    = adv && q_vld_i && (cur_hit || !any_hit);
  assign q_pop_o  = issue && (!any_hit || cur_last);

  assign cnt   = p1_nov_q ? '0 : (p1_fwd_q ? fwd_q : (p1_cv_q ? rdata : '0));
  assign full  = !p1_nov_q && (cnt == CountMax);
  assign we    = adv && p1_vld_q && !p1_nov_q && !full;
  assign wdata = cnt + 1'b1;

  ugbb_ram #(.Width(CountW), .Depth(NumVox)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (p1_idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (issue && any_hit),
    .raddr_i (sc_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q     <= '0;
      p1_vld_q <= 1'b0;
      ov_q     <= 1'b0;
      vbit_q   <= '0;
    end else begin
      if (q_vld_i) begin
        if (!any_hit) begin
          if (issue) sc_q <= '0;
        end else if (cur_hit) begin
          if (issue) sc_q <= cur_last ? '0 : sc_q + 1'b1;
        end else begin
          sc_q <= sc_q + 1'b1;  // skip a miss
        end
      end
      if (adv)      p1_vld_q <= issue;
      if (out_free) ov_q     <= p1_vld_q;
      if (we)       vbit_q[p1_idx_q[AddrW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_idx_q  <= any_hit ? sc_q : '0;
      p1_tag_q  <= any_hit ? q_head_i.tag : '0;
      p1_nov_q  <= !any_hit;
      p1_last_q <= !any_hit || cur_last;
      // same-voxel write in this cycle: the RAM returns old data, so forward
      p1_fwd_q  <= we && (p1_idx_q == sc_q);
      p1_cv_q   <= vbit_q[sc_q[AddrW-1:0]];
      fwd_q     <= wdata;
    end
    if (out_free && p1_vld_q) begin
      res_q.voxel_index <= p1_idx_q;
      res_q.tag_out     <= p1_tag_q;
      res_q.slot        <= cnt;
      res_q.count_full  <= full;
      res_q.no_voxel    <= p1_nov_q;
      res_q.last        <= p1_last_q;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.voxel_index = res_q.voxel_index;
  assign res_o.tag_out     = res_q.tag_out;
  assign res_o.slot        = res_q.slot;
  assign res_o.count_full  = res_q.count_full;
  assign res_o.no_voxel    = res_q.no_voxel;
  assign res_o.last        = res_q.last;

`ifndef SYNTHESIS
  a_nov_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_q.no_voxel) |-> (res_q.last && res_q.slot == '0))
    else $error("empty-box word must be last with zero slot");
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (wdata != '0))
    else $error("voxel count wrapped");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sc_q} < (VoxIdxW+1)'(NumVox))
    else $error("scan index out of grid");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (p1_vld_q && p1_last_q))
    else $error("box retired without a last word");
`endif
endmodule

// File: design/uniform_grid_box_binning.sv
// Uniform grid box binning top level: front classifier, box queue, voxel scan.
// Path: an accepted box waits in the input stage and is classified into the queue;
// each hit voxel then issues a count read into stage 1 and a registered result word.
// Throughput: the scan walks voxels 0 up to the box's last hit, one per cycle,
// but waits on a hit voxel while the result output stalls; an empty box gives one word.
// Reset: asynchronous active low; voxel counts read as zero via per-entry
// valid bits, no clearing pass.
module uniform_grid_box_binning import ugbb_pkg::*; #(
  parameter int GRID_DIM = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  ugbb_box_if.sink           box_i,
  ugbb_res_if.source         res_o
);
  logic  push, full, q_vld, q_pop;
  qent_t push_data, q_head;

  ugbb_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .box_i       (box_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ugbb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .vld_o       (q_vld),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  ugbb_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_head_i (q_head),
    .q_pop_o  (q_pop),
    .res_o    (res_o)
  );
endmodule
